@@ rtl/core/ieeseq_pkg.sv @@
// ----------------------------------------------------------------------------
// ieeseq_pkg
// Shared types, codes and sizes of the I2C EEPROM transaction sequencer.
// ----------------------------------------------------------------------------
package ieeseq_pkg;

  localparam int AddrWidth  = 16;
  localparam int CountWidth = 16;
  localparam int MaxRes     = 3;
  localparam int FifoDepth  = 8;
  localparam int FifoPtrW   = $clog2(FifoDepth);
  localparam int FifoCntW   = $clog2(FifoDepth + 1);
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 16;

  localparam logic [6:0]  DevAddrRst   = 7'd80;
  localparam logic [1:0]  AddrBytesRst = 2'd2;
  localparam logic [2:0]  PageLog2Rst  = 3'd3;
  localparam logic [15:0] PollLimitRst = 16'd1000;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_BUS   = 2'd2,
    OP_DATA  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CMD_START = 3'd0,
    CMD_STOP  = 3'd1,
    CMD_SEND  = 3'd2,
    CMD_READ  = 3'd3,
    CMD_ACK   = 3'd4,
    CMD_NACK  = 3'd5,
    CMD_NEED  = 3'd6
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEV_ADDR   = 2'd0,
    REG_ADDR_BYTES = 2'd1,
    REG_PAGE_LOG2  = 2'd2,
    REG_POLL_LIMIT = 2'd3
  } reg_e;

  typedef struct packed {
    logic [6:0]  dev_addr;
    logic [1:0]  addr_bytes;
    logic [2:0]  page_log2;
    logic [15:0] poll_limit;
  } cfg_t;

  typedef struct packed {
    op_e         op;
    logic [15:0] mem_address;
    logic [15:0] byte_count;
    logic        nack;
    logic [7:0]  rx_byte;
    logic [7:0]  write_byte;
  } item_t;

  typedef struct packed {
    cmd_e       command;
    logic [7:0] tx_byte;
    logic [7:0] read_data;
    logic       read_valid;
    logic       done_res;
    logic       success;
    logic       last;
  } res_t;

  // Up to three results produced by one request, written to the queue together.
  typedef struct packed {
    logic [1:0]              cnt;
    res_t [MaxRes-1:0]       res;
  } push_t;

  function automatic res_t mk_res(cmd_e cmd, logic [7:0] tx, logic [7:0] rd,
                                  logic rv, logic dn, logic ok);
    res_t r;
    r.command    = cmd;
    r.tx_byte    = tx;
    r.read_data  = rd;
    r.read_valid = rv;
    r.done_res   = dn;
    r.success    = ok;
    r.last       = 1'b0;
    return r;
  endfunction

endpackage

@@ rtl/core/ieeseq_in_if.sv @@
// ----------------------------------------------------------------------------
// ieeseq_in_if
// Request channel: begin read/write, bus responses and write data bytes.
// ----------------------------------------------------------------------------
interface ieeseq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] mem_address;
  logic [15:0] byte_count;
  logic        nack;
  logic [7:0]  rx_byte;
  logic [7:0]  write_byte;

  modport source (
    output valid, op, mem_address, byte_count, nack, rx_byte, write_byte,
    input  ready
  );
  modport sink (
    input  valid, op, mem_address, byte_count, nack, rx_byte, write_byte,
    output ready
  );
endinterface

@@ rtl/core/ieeseq_out_if.sv @@
// ----------------------------------------------------------------------------
// ieeseq_out_if
// Result channel: one bus command or status result per handshake.
// ----------------------------------------------------------------------------
interface ieeseq_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] tx_byte;
  logic [7:0] read_data;
  logic       read_valid;
  logic       done_res;
  logic       success;
  logic       last;

  modport source (
    output valid, command, tx_byte, read_data, read_valid, done_res, success, last,
    input  ready
  );
  modport sink (
    input  valid, command, tx_byte, read_data, read_valid, done_res, success, last,
    output ready
  );
endinterface

@@ rtl/core/i2c_eeprom_transaction_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// i2c_eeprom_transaction_sequencer_unit
// Turns 24-series EEPROM read/write requests into byte-level I2C commands.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries requests: begin read, begin write (address and count),
//   bus responses (nack or received byte) and write data bytes. rsp_if carries
//   the resulting bus commands and status, one result per handshake; last
//   marks the final result of a request.
//   A request is registered in the core, decoded into up to three results
//   and written to the result queue, whose head is presented on rsp_if.
//   Requests are accepted at one per cycle while the result queue (eight
//   entries) holds two results or fewer; a request that yields k results
//   occupies the result channel for k handshakes, so that side sets the rate.
//   When the receiver stalls, results collect in the queue and req_if.ready
//   drops; nothing is lost.
//   Reset empties the queue, returns to idle and loads the register defaults
//   (device 80, two address bytes, 8-byte pages, 1000 polls). Write registers
//   through cfg_we_i / cfg_idx_i / cfg_data_i only while the block is idle.
// ----------------------------------------------------------------------------
module i2c_eeprom_transaction_sequencer_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ieeseq_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ieeseq_pkg::CfgDataW-1:0] cfg_data_i,
  ieeseq_in_if.sink                      req_if,
  ieeseq_out_if.source                   rsp_if
);
  import ieeseq_pkg::*;

  cfg_t  cfg_q;
  item_t item;
  push_t push;
  res_t  head;
  logic  accept;
  logic  pop;
  logic  space;
  logic  valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dev_addr   <= DevAddrRst;
      cfg_q.addr_bytes <= AddrBytesRst;
      cfg_q.page_log2  <= PageLog2Rst;
      cfg_q.poll_limit <= PollLimitRst;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_DEV_ADDR:   cfg_q.dev_addr   <= cfg_data_i[6:0];
        REG_ADDR_BYTES: cfg_q.addr_bytes <= cfg_data_i[1:0];
        REG_PAGE_LOG2:  cfg_q.page_log2  <= cfg_data_i[2:0];
        REG_POLL_LIMIT: cfg_q.poll_limit <= cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end

  assign item.op          = op_e'(req_if.op);
  assign item.mem_address = req_if.mem_address;
  assign item.byte_count  = req_if.byte_count;
  assign item.nack        = req_if.nack;
  assign item.rx_byte     = req_if.rx_byte;
  assign item.write_byte  = req_if.write_byte;

  assign req_if.ready = space;
  assign accept       = req_if.valid && space;

  ieeseq_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item),
    .cfg_i    (cfg_q),
    .push_o   (push)
  );

  assign pop = valid && rsp_if.ready;

  ieeseq_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .valid_o (valid),
    .head_o  (head),
    .space_o (space)
  );

  assign rsp_if.valid      = valid;
  assign rsp_if.command    = head.command;
  assign rsp_if.tx_byte    = head.tx_byte;
  assign rsp_if.read_data  = head.read_data;
  assign rsp_if.read_valid = head.read_valid;
  assign rsp_if.done_res   = head.done_res;
  assign rsp_if.success    = head.success;
  assign rsp_if.last       = head.last;

endmodule

@@ rtl/core/ieeseq_core.sv @@
// ----------------------------------------------------------------------------
// ieeseq_core
// Request register, transaction state and next-state logic; emits up to three
// results per request.
// ----------------------------------------------------------------------------
module ieeseq_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  ieeseq_pkg::item_t   item_i,
  input  ieeseq_pkg::cfg_t    cfg_i,
  output ieeseq_pkg::push_t   push_o
);
  import ieeseq_pkg::*;

  typedef enum logic [7:0] {
    PH_IDLE      = 8'b0000_0001,
    PH_DEV_ACK   = 8'b0000_0010,
    PH_HI_ACK    = 8'b0000_0100,
    PH_LO_ACK    = 8'b0000_1000,
    PH_DEVR_ACK  = 8'b0001_0000,
    PH_READ_WAIT = 8'b0010_0000,
    PH_DATA_WAIT = 8'b0100_0000,
    PH_DATA_ACK  = 8'b1000_0000
  } phase_e;

  item_t                 item_q;
  logic                  item_vld_q;
  phase_e                phase_q, phase_d;
  logic                  is_write_q, is_write_d;
  logic [AddrWidth-1:0]  cur_addr_q, cur_addr_d;
  logic [CountWidth-1:0] left_q, left_d;
  logic [15:0]           poll_q, poll_d;

  logic [AddrWidth-1:0]  cur_inc;
  logic [CountWidth-1:0] left_dec;
  logic [15:0]           poll_inc;
  logic [AddrWidth-1:0]  page_mask;
  logic [15:0]           addr_ext;
  logic [7:0]            dev_wr, dev_rd;
  res_t [MaxRes-1:0]     r;
  logic [1:0]            n;

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      item_q <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      phase_q    <= PH_IDLE;
      is_write_q <= 1'b0;
      cur_addr_q <= '0;
      left_q     <= '0;
      poll_q     <= '0;
    end else begin
      item_vld_q <= accept_i;
      phase_q    <= phase_d;
      is_write_q <= is_write_d;
      cur_addr_q <= cur_addr_d;
      left_q     <= left_d;
      poll_q     <= poll_d;
    end
  end

  assign cur_inc   = cur_addr_q + AddrWidth'(1);
  assign left_dec  = left_q - CountWidth'(1);
  assign poll_inc  = (poll_q != 16'hFFFF) ? poll_q + 16'd1 : poll_q;
  assign page_mask = ~({AddrWidth{1'b1}} << cfg_i.page_log2);
  assign addr_ext  = 16'(cur_addr_q);
  assign dev_wr    = {cfg_i.dev_addr, 1'b0};
  assign dev_rd    = {cfg_i.dev_addr, 1'b1};

  always_comb begin
    phase_d    = phase_q;
    is_write_d = is_write_q;
    cur_addr_d = cur_addr_q;
    left_d     = left_q;
    poll_d     = poll_q;
    r          = '0;
    n          = 2'd0;

    if (item_vld_q) begin
      case (item_q.op)
        OP_READ, OP_WRITE: begin
          if (phase_q == PH_IDLE) begin
            is_write_d = (item_q.op == OP_WRITE);
            cur_addr_d = item_q.mem_address[AddrWidth-1:0];
            left_d     = item_q.byte_count[CountWidth-1:0];
            poll_d     = '0;
            if (item_q.op == OP_READ) begin
              r[0]    = mk_res(CMD_START, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
              r[1]    = mk_res(CMD_SEND, dev_wr, 8'h00, 1'b0, 1'b0, 1'b0);
              n       = 2'd2;
              phase_d = PH_DEV_ACK;
            end else if (item_q.byte_count[CountWidth-1:0] == '0) begin
              r[0]    = mk_res(CMD_STOP, 8'h00, 8'h00, 1'b0, 1'b1, 1'b1);
              n       = 2'd1;
              phase_d = PH_IDLE;
            end else begin
              // stop, then start polling the device for write readiness
              r[0]    = mk_res(CMD_STOP, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
              r[1]    = mk_res(CMD_START, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
              r[2]    = mk_res(CMD_SEND, dev_wr, 8'h00, 1'b0, 1'b0, 1'b0);
              n       = 2'd3;
              phase_d = PH_DEV_ACK;
            end
          end
        end
        OP_DATA: begin
          if (phase_q == PH_DATA_WAIT) begin
            r[0]    = mk_res(CMD_SEND, item_q.write_byte, 8'h00, 1'b0, 1'b0, 1'b0);
            n       = 2'd1;
            phase_d = PH_DATA_ACK;
          end
        end
        OP_BUS: begin
          case (phase_q)
            PH_DEV_ACK: begin
              if (!item_q.nack) begin
                n = 2'd1;
                if (cfg_i.addr_bytes == 2'd1) begin
                  r[0]    = mk_res(CMD_SEND, addr_ext[7:0], 8'h00, 1'b0, 1'b0, 1'b0);
                  phase_d = PH_LO_ACK;
                end else begin
                  r[0]    = mk_res(CMD_SEND, addr_ext[15:8], 8'h00, 1'b0, 1'b0, 1'b0);
                  phase_d = PH_HI_ACK;
                end
              end else if (is_write_q) begin
                poll_d = poll_inc;
                if (poll_inc >= cfg_i.poll_limit) begin
                  r[0]    = mk_res(CMD_STOP, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0);
                  n       = 2'd1;
                  phase_d = PH_IDLE;
                end else begin
                  r[0] = mk_res(CMD_START, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
                  r[1] = mk_res(CMD_SEND, dev_wr, 8'h00, 1'b0, 1'b0, 1'b0);
                  n    = 2'd2;
                end
              end else begin
                r[0]    = mk_res(CMD_STOP, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0);
                n       = 2'd1;
                phase_d = PH_IDLE;
              end
            end
            PH_HI_ACK: begin
              n = 2'd1;
              if (item_q.nack) begin
                r[0]    = mk_res(CMD_STOP, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0);
                phase_d = PH_IDLE;
              end else begin
                r[0]    = mk_res(CMD_SEND, addr_ext[7:0], 8'h00, 1'b0, 1'b0, 1'b0);
                phase_d = PH_LO_ACK;
              end
            end
            PH_LO_ACK: begin
              if (item_q.nack) begin
                r[0]    = mk_res(CMD_STOP, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0);
                n       = 2'd1;
                phase_d = PH_IDLE;
              end else if (is_write_q) begin
                r[0]    = mk_res(CMD_NEED, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
                n       = 2'd1;
                phase_d = PH_DATA_WAIT;
              end else begin
                // restart with the read device byte
                r[0]    = mk_res(CMD_START, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
                r[1]    = mk_res(CMD_SEND, dev_rd, 8'h00, 1'b0, 1'b0, 1'b0);
                n       = 2'd2;
                phase_d = PH_DEVR_ACK;
              end
            end
            PH_DEVR_ACK: begin
              n = 2'd1;
              if (item_q.nack) begin
                r[0]    = mk_res(CMD_STOP, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0);
                phase_d = PH_IDLE;
              end else if (left_q == '0) begin
                r[0]    = mk_res(CMD_STOP, 8'h00, 8'h00, 1'b0, 1'b1, 1'b1);
                phase_d = PH_IDLE;
              end else begin
                r[0]    = mk_res(CMD_READ, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
                phase_d = PH_READ_WAIT;
              end
            end
            PH_READ_WAIT: begin
              left_d     = left_dec;
              cur_addr_d = cur_inc;
              n          = 2'd2;
              if (left_dec == '0) begin
                r[0]    = mk_res(CMD_NACK, 8'h00, item_q.rx_byte, 1'b1, 1'b0, 1'b0);
                r[1]    = mk_res(CMD_STOP, 8'h00, 8'h00, 1'b0, 1'b1, 1'b1);
                phase_d = PH_IDLE;
              end else begin
                r[0] = mk_res(CMD_ACK, 8'h00, item_q.rx_byte, 1'b1, 1'b0, 1'b0);
                r[1] = mk_res(CMD_READ, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
              end
            end
            PH_DATA_ACK: begin
              if (item_q.nack) begin
                r[0]    = mk_res(CMD_STOP, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0);
                n       = 2'd1;
                phase_d = PH_IDLE;
              end else begin
                cur_addr_d = cur_inc;
                left_d     = left_dec;
                if (left_dec == '0) begin
                  r[0]    = mk_res(CMD_STOP, 8'h00, 8'h00, 1'b0, 1'b1, 1'b1);
                  n       = 2'd1;
                  phase_d = PH_IDLE;
                end else if ((cur_inc & page_mask) == '0) begin
                  // page boundary: commit the page and poll again
                  poll_d  = '0;
                  r[0]    = mk_res(CMD_STOP, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
                  r[1]    = mk_res(CMD_START, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
                  r[2]    = mk_res(CMD_SEND, dev_wr, 8'h00, 1'b0, 1'b0, 1'b0);
                  n       = 2'd3;
                  phase_d = PH_DEV_ACK;
                end else begin
                  r[0]    = mk_res(CMD_NEED, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
                  n       = 2'd1;
                  phase_d = PH_DATA_WAIT;
                end
              end
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end

    if (n != 2'd0) begin
      r[n - 2'd1].last = 1'b1;
    end
  end

  assign push_o.cnt = n;
  assign push_o.res = r;

  a_data_wait_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA_WAIT) |-> (left_q != '0))
    else $error("data wait with no bytes left");

  a_read_wait_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_vld_q && item_q.op == OP_BUS && phase_q == PH_READ_WAIT) |-> (n == 2'd2))
    else $error("read response must give an acknowledge and a follow-up");

  a_done_ends_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n != 2'd0 && r[n - 2'd1].done_res) |=> (phase_q == PH_IDLE))
    else $error("transaction done without returning to idle");

  a_begin_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_vld_q && (item_q.op == OP_READ || item_q.op == OP_WRITE) &&
     phase_q != PH_IDLE) |-> (n == 2'd0))
    else $error("begin request while busy produced results");

endmodule

@@ rtl/core/ieeseq_fifo.sv @@
// ----------------------------------------------------------------------------
// ieeseq_fifo
// Result queue: takes up to three results per cycle, delivers one per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module ieeseq_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ieeseq_pkg::push_t   push_i,
  input  logic                pop_i,
  output logic                valid_o,
  output ieeseq_pkg::res_t    head_o,
  output logic                space_o
);
  import ieeseq_pkg::*;

  res_t                mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0] count_q, count_d;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MaxRes; k++) begin
      if (2'(k) < push_i.cnt) begin
        mem_q[wr_ptr_q + FifoPtrW'(k)] <= push_i.res[k];
      end
    end
  end

  assign count_d = count_q + FifoCntW'(push_i.cnt) - FifoCntW'(pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + FifoPtrW'(push_i.cnt);
      rd_ptr_q <= rd_ptr_q + FifoPtrW'(pop_i);
      count_q  <= count_d;
    end
  end

  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  // leave room for the request in flight plus a new one
  assign space_o = (count_q <= FifoCntW'(FifoDepth - 2 * MaxRes));

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FifoCntW'(FifoDepth))
    else $error("result queue overflow");

  a_count_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.cnt == 2'd0 && !pop_i) |=> $stable(count_q))
    else $error("result count changed without push or pop");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("pop from empty result queue");

endmodule
